FILE: hdl/qsld_pkg.sv
// Shared types, constants and lookup functions of the QOA slice LMS decoder.
`default_nettype none

package qsld_pkg;

    localparam int CHAN_COUNT_DEF   = 2;
    localparam int TAPS             = 4;
    localparam int SLICE_LEN        = 20;
    localparam int CNT_W            = $clog2(SLICE_LEN);

    localparam logic [1:0] FUNC_LOAD_HIST = 2'd0;
    localparam logic [1:0] FUNC_LOAD_WTS  = 2'd1;
    localparam logic [1:0] FUNC_SLICE     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_hist;
        logic load_wts;
        logic start;
        logic mul_en;
        logic step;
        logic last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } sts_t;

    // Scale factor round((idx+1)^2.75).
    function automatic logic [11:0] scale_factor(input logic [3:0] idx);
        logic [11:0] sf;
        begin
            unique case (idx)
                4'd0:    sf = 12'd1;
                4'd1:    sf = 12'd7;
                4'd2:    sf = 12'd21;
                4'd3:    sf = 12'd45;
                4'd4:    sf = 12'd84;
                4'd5:    sf = 12'd138;
                4'd6:    sf = 12'd211;
                4'd7:    sf = 12'd304;
                4'd8:    sf = 12'd421;
                4'd9:    sf = 12'd562;
                4'd10:   sf = 12'd731;
                4'd11:   sf = 12'd928;
                4'd12:   sf = 12'd1157;
                4'd13:   sf = 12'd1419;
                4'd14:   sf = 12'd1715;
                default: sf = 12'd2048;
            endcase
            return sf;
        end
    endfunction

    // Dequantization multiplier magnitude in quarters: 0.75, 2.5, 4.5, 7.
    function automatic logic [4:0] quarter_mag(input logic [1:0] sel);
        logic [4:0] qm;
        begin
            unique case (sel)
                2'd0:    qm = 5'd3;
                2'd1:    qm = 5'd10;
                2'd2:    qm = 5'd18;
                default: qm = 5'd28;
            endcase
            return qm;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/qsld_ctrl.sv
// Controller state machine of the QOA slice LMS decoder.
`default_nettype none

module qsld_ctrl
    import qsld_pkg::*;
#(
    parameter int CHAN_COUNT = CHAN_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic       channel,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_ACC  = 3'b100
    } state_t;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLICE_LEN - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             ch_ok;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign ch_ok    = (int'(channel) < CHAN_COUNT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ch_ok)
                begin
                    cmd.load_hist = (func == FUNC_LOAD_HIST);
                    cmd.load_wts  = (func == FUNC_LOAD_WTS);
                    if (func == FUNC_SLICE)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // hold the products until the output register can take the sample
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    cmd.last = (cnt_reg == LAST_IDX);
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> sts.out_free)
        else $error("sample step issued while output register is occupied");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_IDX)
        else $error("sample counter beyond slice length");

    a_last_ends_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.last) |=> (state_reg == ST_IDLE) && (cnt_reg == '0))
        else $error("slice did not end after its last sample");

    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_MUL) && (cnt_reg == '0))
        else $error("slice start did not enter multiply phase");
`endif

endmodule

`default_nettype wire

FILE: hdl/qsld_dp.sv
// Datapath of the QOA slice LMS decoder: LMS state, predictor, output register.
`default_nettype none

module qsld_dp
    import qsld_pkg::*;
#(
    parameter int CHAN_COUNT = CHAN_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic               channel,
    input  wire logic [63:0]        payload,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    output logic                    sample_channel,
    output logic                    last
);

    localparam int CH_W = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam logic signed [21:0] S_MIN = -22'sd32768;
    localparam logic signed [21:0] S_MAX = 22'sd32767;

    logic signed [15:0] hist_reg [CHAN_COUNT][TAPS];
    logic signed [15:0] wts_reg  [CHAN_COUNT][TAPS];

    logic [CH_W-1:0]    ch_in;
    logic [CH_W-1:0]    ch_reg;
    logic [3:0]         sf_idx_reg;
    logic [59:0]        codes_reg;
    logic signed [31:0] prod_reg [TAPS];
    logic signed [14:0] r_reg, r_next;

    logic               out_valid_reg;
    logic signed [15:0] sample_reg;
    logic               sample_channel_reg;
    logic               last_reg;

    logic [2:0]         code;
    logic [16:0]        q_prod;
    logic [13:0]        mag;
    logic signed [33:0] acc;
    logic signed [20:0] pred;
    logic signed [21:0] s_full;
    logic signed [15:0] s_next;
    logic signed [10:0] delta;
    logic signed [15:0] wts_next [TAPS];

    assign ch_in = CH_W'(channel);

    // Residual of the current code, rounded half away from zero.
    assign code   = codes_reg[59:57];
    assign q_prod = 17'(scale_factor(sf_idx_reg)) * 17'(quarter_mag(code[2:1])) + 17'd2;
    assign mag    = 14'(q_prod >> 2);
    assign r_next = code[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // Prediction, sum and clamp.
    always_comb
    begin
        acc = '0;
        for (int n = 0; n < TAPS; n++)
        begin
            acc = acc + 34'(prod_reg[n]);
        end
        pred   = 21'(acc >>> 13);
        s_full = 22'(pred) + 22'(r_reg);
        if (s_full < S_MIN)
        begin
            s_next = 16'sh8000;
        end
        else if (s_full > S_MAX)
        begin
            s_next = 16'sh7fff;
        end
        else
        begin
            s_next = 16'(s_full);
        end
    end

    // Weight adaptation of the active channel by the sign of each history tap.
    assign delta = 11'(r_reg >>> 4);
    always_comb
    begin
        for (int n = 0; n < TAPS; n++)
        begin
            if (hist_reg[ch_reg][n][15])
            begin
                wts_next[n] = wts_reg[ch_reg][n] - 16'(delta);
            end
            else
            begin
                wts_next[n] = wts_reg[ch_reg][n] + 16'(delta);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                for (int n = 0; n < TAPS; n++)
                begin
                    hist_reg[i][n] <= '0;
                    wts_reg[i][n]  <= '0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                if (cmd.load_hist && (int'(ch_in) == i))
                begin
                    for (int n = 0; n < TAPS; n++)
                    begin
                        hist_reg[i][n] <= payload[63 - 16 * n -: 16];
                    end
                end
                else if (cmd.step && (int'(ch_reg) == i))
                begin
                    for (int n = 0; n < TAPS - 1; n++)
                    begin
                        hist_reg[i][n] <= hist_reg[i][n + 1];
                    end
                    hist_reg[i][TAPS - 1] <= s_next;
                end

                if (cmd.load_wts && (int'(ch_in) == i))
                begin
                    for (int n = 0; n < TAPS; n++)
                    begin
                        wts_reg[i][n] <= payload[63 - 16 * n -: 16];
                    end
                end
                else if (cmd.step && (int'(ch_reg) == i))
                begin
                    for (int n = 0; n < TAPS; n++)
                    begin
                        wts_reg[i][n] <= wts_next[n];
                    end
                end
            end
        end
    end

    // Slice context, code shifter and tap products.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ch_reg     <= ch_in;
            sf_idx_reg <= payload[63:60];
            codes_reg  <= payload[59:0];
        end
        else if (cmd.step)
        begin
            codes_reg <= {codes_reg[56:0], 3'b000};
        end

        if (cmd.mul_en)
        begin
            r_reg <= r_next;
            for (int n = 0; n < TAPS; n++)
            begin
                prod_reg[n] <= 32'(hist_reg[ch_reg][n]) * 32'(wts_reg[ch_reg][n]);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            sample_reg         <= s_next;
            sample_channel_reg <= ch_reg[0];
            last_reg           <= cmd.last;
        end
    end

    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign sample          = sample_reg;
    assign sample_channel  = sample_channel_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

FILE: hdl/qoa_slice_lms_decoder.sv
// Top level of the QOA slice LMS decoder: controller plus datapath.
//
// Input channel (in_valid / in_stall) takes one item per handshake: func selects
// load history, load weights or decode slice; channel picks the LMS state;
// payload holds four 16-bit values (first in the top bits) or a 4-bit scale
// index followed by twenty 3-bit residual codes. Unused func codes and channels
// at or above CHAN_COUNT are taken and dropped.
// Output channel (out_valid / out_stall) delivers one PCM sample per item with
// its channel, and last marks the twentieth sample of a slice.
// Timing: a load item does not stall the input. A slice runs its samples one
// after the other, each in a multiply state that forms the four tap products
// and the residual, then an accumulate state that sums, clamps, emits the
// sample and adapts the weights. The input stays stalled for the whole slice,
// so no new item is taken before the slice ends; the four-tap history/weight
// feedback loop through the multipliers keeps its samples from overlapping.
// A stalled output holds the finished sample in the output register and
// freezes the slice until the receiver takes it; the input stays stalled
// meanwhile. Reset clears all history and weights to zero and empties the
// output register.
`default_nettype none

module qoa_slice_lms_decoder
    import qsld_pkg::*;
#(
    parameter int CHAN_COUNT = CHAN_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic               channel,
    input  wire logic [63:0]        payload,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    output logic                    sample_channel,
    output logic                    last
);

    cmd_t cmd;
    sts_t sts;

    // Sequence loads and the per-sample multiply / accumulate phases.
    qsld_ctrl #(
        .CHAN_COUNT (CHAN_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .channel  (channel),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the LMS state, compute each sample and register the result item.
    qsld_dp #(
        .CHAN_COUNT (CHAN_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .channel        (channel),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample         (sample),
        .sample_channel (sample_channel),
        .last           (last)
    );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the QOA slice LMS decoder: directed and random items.
module testbench
    import qsld_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_GAP      = 40;
    localparam int HOLD_CYCLES  = 300;

    // The one func code the block must drop without a result.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // One decoded PCM sample as it should leave the block.
    typedef struct {
        logic signed [15:0] pcm;
        logic               chan;
        logic               last;
    } pcm_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = FUNC_LOAD_HIST;
    logic               channel = 1'b0;
    logic [63:0]        payload = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] sample;
    logic               sample_channel;
    logic               last;

    // Mirror of the per-channel LMS state, kept in step with accepted items.
    logic signed [15:0] lms_hist [2][4];
    logic signed [15:0] lms_wts  [2][4];

    // Scale factors round((idx+1)^2.75) and dequantization steps in quarters.
    int scale_lut   [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                             421, 562, 731, 928, 1157, 1419, 1715, 2048};
    int quarter_lut [8]  = '{3, -3, 10, -10, 18, -18, 28, -28};

    pcm_result_t pending_pcm[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left     = 0;

    qoa_slice_lms_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .channel        (channel),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample         (sample),
        .sample_channel (sample_channel),
        .last           (last)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Abort a hung run; the limit covers every item at its slowest by a wide margin.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("qoa_slice_lms_decoder verification failed");
            $finish;
        end
    end

    // Count down a long receiver hold-off in its own process.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Stall the output at random, or solidly while a hold-off runs.
    always @(posedge clk)
    begin
        out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Advance the mirrored LMS state by one accepted item and queue its samples.
    function automatic void decode_into_queue(input logic [1:0] f, input logic ch,
                                              input logic [63:0] pay);
        int          sf;
        int          q;
        int          mag;
        int          resid;
        int          delta;
        longint      acc;
        longint      pcm;
        logic [2:0]  code;
        pcm_result_t res;

        if (f == FUNC_LOAD_HIST)
        begin
            for (int n = 0; n < TAPS; n++)
                lms_hist[ch][n] = pay[63 - 16 * n -: 16];
        end
        else if (f == FUNC_LOAD_WTS)
        begin
            for (int n = 0; n < TAPS; n++)
                lms_wts[ch][n] = pay[63 - 16 * n -: 16];
        end
        else if (f == FUNC_SLICE)
        begin
            sf = scale_lut[pay[63:60]];
            for (int k = 0; k < SLICE_LEN; k++)
            begin
                code  = pay[59 - 3 * k -: 3];
                q     = quarter_lut[code];
                // Round half away from zero on the magnitude.
                mag   = (sf * (q < 0 ? -q : q) + 2) >>> 2;
                resid = (q < 0) ? -mag : mag;

                acc = 0;
                for (int n = 0; n < TAPS; n++)
                    acc += longint'(lms_hist[ch][n]) * longint'(lms_wts[ch][n]);
                pcm = (acc >>> 13) + resid;
                if (pcm < -32768)
                    pcm = -32768;
                if (pcm > 32767)
                    pcm = 32767;

                res.pcm  = 16'(pcm);
                res.chan = ch;
                res.last = (k == SLICE_LEN - 1);
                pending_pcm = {pending_pcm, res};

                // Adapt weights by the sign of each history tap, wrapping at 16 bits.
                delta = resid >>> 4;
                for (int n = 0; n < TAPS; n++)
                begin
                    if (lms_hist[ch][n] < 0)
                        lms_wts[ch][n] = lms_wts[ch][n] - 16'(delta);
                    else
                        lms_wts[ch][n] = lms_wts[ch][n] + 16'(delta);
                end
                for (int n = 0; n < TAPS - 1; n++)
                    lms_hist[ch][n] = lms_hist[ch][n + 1];
                lms_hist[ch][TAPS - 1] = 16'(pcm);
            end
        end
    endfunction

    // Compare every taken sample against the oldest one still owed.
    always @(posedge clk)
    begin : check_pcm
        pcm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pcm.size() == 0)
                report_mismatch($sformatf("unexpected sample %0d on channel %0d",
                                          sample, sample_channel));
            else
            begin
                want = pending_pcm.pop_front();
                if (sample !== want.pcm)
                    report_mismatch($sformatf("sample %0d, want %0d", sample, want.pcm));
                if (sample_channel !== want.chan)
                    report_mismatch($sformatf("sample_channel %0d, want %0d",
                                              sample_channel, want.chan));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", last, want.last));
            end
        end
    end

    // Offer one item, hold it until taken, then maybe go idle for a while.
    // Leave valid high when no gap follows so back-to-back items flow.
    task automatic send_item(input logic [1:0] f, input logic ch, input logic [63:0] pay);
        int gap;
        in_valid <= 1'b1;
        func     <= f;
        channel  <= ch;
        payload  <= pay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_into_queue(f, ch, pay);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] pack_taps(input int t0, input int t1,
                                              input int t2, input int t3);
        return {16'(t0), 16'(t1), 16'(t2), 16'(t3)};
    endfunction

    // Build a slice whose codes run first, first+stride, ... modulo 8.
    function automatic logic [63:0] slice_word(input logic [3:0] sf_idx, input int first,
                                               input int stride);
        logic [63:0] w;
        w = '0;
        w[63:60] = sf_idx;
        for (int k = 0; k < SLICE_LEN; k++)
            w[59 - 3 * k -: 3] = 3'((first + stride * k) % 8);
        return w;
    endfunction

    // Draw four taps, either full range or within +/- span for realistic state.
    function automatic logic [63:0] random_taps(input int span);
        if ($urandom_range(1))
            return {$urandom, $urandom};
        return pack_taps($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                         $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
    endfunction

    // Drive extremes, both clamp directions, every code, both tap signs and the dropped func.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(FUNC_LOAD_HIST, 1'b0, pack_taps(32767, -32768, 32767, -32768));
        send_item(FUNC_LOAD_WTS,  1'b0, pack_taps(32767, -32768, -32768, 32767));
        send_item(FUNC_SLICE,     1'b0, slice_word(4'd15, 6, 0));
        send_item(FUNC_SLICE,     1'b0, slice_word(4'd15, 7, 0));
        send_item(FUNC_SLICE,     1'b1, slice_word(4'd0, 0, 1));
        send_item(FUNC_SLICE,     1'b1, slice_word(4'd7, 3, 1));
        send_item(FUNC_LOAD_HIST, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_LOAD_WTS,  1'b1, pack_taps(16384, -8192, 4096, -2048));
        send_item(FUNC_SLICE,     1'b1, slice_word(4'd10, 5, 3));
        send_item(FUNC_UNUSED,    1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_UNUSED,    1'b1, 64'h0);
        send_item(FUNC_SLICE,     1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_SLICE,     1'b0, 64'h0);
        send_item(FUNC_LOAD_HIST, 1'b0, 64'h0);
        send_item(FUNC_LOAD_WTS,  1'b0, pack_taps(-32768, -32768, -32768, -32768));
        send_item(FUNC_SLICE,     1'b0, slice_word(4'd3, 2, 3));
        send_item(FUNC_LOAD_HIST, 1'b1, 64'h0);
        send_item(FUNC_LOAD_WTS,  1'b1, 64'h0);
        send_item(FUNC_SLICE,     1'b1, slice_word(4'd12, 1, 5));
    endtask

    // Mostly slices over plausible LMS state, with loads and dropped items mixed in.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int taken;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        taken = 0;
        while (taken < count)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_item(FUNC_UNUSED, 1'($urandom), {$urandom, $urandom});
            else
            begin
                if (pick < 25)
                    send_item(FUNC_LOAD_HIST, 1'($urandom), random_taps(4096));
                else if (pick < 42)
                    send_item(FUNC_LOAD_WTS, 1'($urandom), random_taps(16384));
                else
                    send_item(FUNC_SLICE, 1'($urandom), {$urandom, $urandom});
                taken++;
            end
        end
    endtask

    // Hold off the receiver for a long stretch while slices keep coming,
    // so the output register fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left     <= HOLD_CYCLES;
        for (int i = 0; i < 4; i++)
            send_item(FUNC_SLICE, 1'($urandom), {$urandom, $urandom});
    endtask

    initial
    begin
        for (int c = 0; c < 2; c++)
            for (int n = 0; n < TAPS; n++)
            begin
                lms_hist[c][n] = '0;
                lms_wts[c][n]  = '0;
            end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(25, 0, 0);
        test_random_traffic(25, 57, 0);
        test_random_traffic(25, 0, 57);
        test_random_traffic(25, 6, 6);
        test_backpressure();

        // Drop valid, let the last samples drain, then give the block time to settle.
        in_valid <= 1'b0;
        while (pending_pcm.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("qoa_slice_lms_decoder verification clean");
        else
            $display("qoa_slice_lms_decoder verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/qsld_pkg.sv
hdl/qsld_ctrl.sv
hdl/qsld_dp.sv
hdl/qoa_slice_lms_decoder.sv
test/testbench.sv
